// File: rtl/des_pkg.sv
// ----------------------------------------------------------------------------
// DES package
// Permutation tables, S-boxes and helper functions shared by the DES modules.
// ----------------------------------------------------------------------------
package des_pkg;

  localparam int unsigned BlockW = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned RkeyW  = 48;
  localparam int unsigned NumRounds = 16;

  typedef logic [BlockW-1:0] block_t;
  typedef logic [HalfW-1:0]  half_t;
  typedef logic [RkeyW-1:0]  rkey_t;

  typedef enum logic {
    REQ_ENCRYPT = 1'b0,
    REQ_DECRYPT = 1'b1
  } req_t;

  localparam logic [7:0] IP_TAB [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

  localparam logic [7:0] FP_TAB [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

  localparam logic [7:0] E_TAB [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

  localparam logic [7:0] P_TAB [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};

  localparam logic [7:0] PC1_TAB [56] = '{
    57,49,41,33,25,17,9,  1,58,50,42,34,26,18,
    10,2,59,51,43,35,27,  19,11,3,60,52,44,36,
    63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29,  21,13,5,28,20,12,4};

  localparam logic [7:0] PC2_TAB [48] = '{
    14,17,11,24,1,5,  3,28,15,6,21,10,  23,19,12,4,26,8,  16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};

  localparam logic [1:0] SHIFT_TAB [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

  localparam logic [3:0] SBOX [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
      0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
      15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
      3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
      13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
      13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
      1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
      13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
      3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
      14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
      11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
      10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
      4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
      13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
      6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
      1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
      2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic block_t init_perm(input block_t v);
    block_t r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64 - int'(IP_TAB[i])];
    return r;
  endfunction

  function automatic block_t final_perm(input block_t v);
    block_t r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64 - int'(FP_TAB[i])];
    return r;
  endfunction

  function automatic logic [55:0] pc1(input block_t v);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = v[64 - int'(PC1_TAB[i])];
    return r;
  endfunction

  function automatic rkey_t pc2(input logic [55:0] v);
    rkey_t r;
    for (int i = 0; i < 48; i++) r[47-i] = v[56 - int'(PC2_TAB[i])];
    return r;
  endfunction

  function automatic logic [27:0] rot28(input logic [27:0] x, input logic [1:0] n);
    logic [27:0] r;
    r = (n == 2'd2) ? {x[25:0], x[27:26]} : {x[26:0], x[27]};
    return r;
  endfunction

  // Feistel function: expansion, key mix, S-boxes, P permutation.
  function automatic half_t feistel(input half_t r, input rkey_t k);
    rkey_t e;
    half_t s;
    half_t p;
    logic [5:0] six;
    for (int i = 0; i < 48; i++) e[47-i] = r[32 - int'(E_TAB[i])];
    e = e ^ k;
    for (int i = 0; i < 8; i++) begin
      six = e[47-6*i -: 6];
      s[31-4*i -: 4] = SBOX[i][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32 - int'(P_TAB[i])];
    return p;
  endfunction

endpackage

// File: rtl/des_key_sched.sv
// ----------------------------------------------------------------------------
// DES key schedule
// Registers the sixteen round keys derived from the key register.
// ----------------------------------------------------------------------------
module des_key_sched (
  input  logic                  clk,
  input  logic [63:0]           cipher_key,
  output des_pkg::rkey_t        rkeys [des_pkg::NumRounds]
);
  import des_pkg::*;

  // The key must only change while the block is idle (the block does not enforce
  // this), so the schedule is flattened and registered once; the register cuts it from the datapath.
  rkey_t       rkeys_r   [NumRounds];
  rkey_t       rkeys_nxt [NumRounds];
  logic [27:0] c [NumRounds+1];
  logic [27:0] d [NumRounds+1];

  always_comb begin
    {c[0], d[0]} = pc1(cipher_key);
    for (int j = 0; j < NumRounds; j++) begin
      c[j+1] = rot28(c[j], SHIFT_TAB[j]);
      d[j+1] = rot28(d[j], SHIFT_TAB[j]);
      rkeys_nxt[j] = pc2({c[j+1], d[j+1]});
    end
  end

  always_ff @(posedge clk) begin
    rkeys_r <= rkeys_nxt;
  end

  assign rkeys = rkeys_r;

endmodule

// File: rtl/des_round.sv
// ----------------------------------------------------------------------------
// DES round stage
// One Feistel round with a stallable pipeline register.
// ----------------------------------------------------------------------------
module des_round (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             vld_i,
  input  logic             dec_i,
  input  des_pkg::half_t   l_i,
  input  des_pkg::half_t   r_i,
  input  des_pkg::rkey_t   key_enc,
  input  des_pkg::rkey_t   key_dec,
  output logic             vld_o,
  output logic             dec_o,
  output des_pkg::half_t   l_o,
  output des_pkg::half_t   r_o
);
  import des_pkg::*;

  logic  vld_r;
  logic  dec_r;
  half_t l_r;
  half_t r_r;
  half_t r_nxt;

  assign r_nxt = l_i ^ feistel(r_i, dec_i ? key_dec : key_enc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dec_r <= dec_i;
      l_r   <= r_i;
      r_r   <= r_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dec_o = dec_r;
  assign l_o   = l_r;
  assign r_o   = r_r;

endmodule

// File: rtl/des_block_cipher.sv
// ----------------------------------------------------------------------------
// DES block cipher
// Fully pipelined DES engine, one 64-bit block per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// The engine takes one block per cycle while the output is not stalled. The
// initial permutation register loads at the edge that accepts a beat. One stage
// per Feistel round (sixteen) follows it, and then the output register after the
// final permutation. The whole pipeline advances together whenever the output
// register is empty or being drained, so out_stall backs up into in_stall in the
// same cycle and no beat is lost or repeated. The user must write the key
// through the cfg port only while the engine is idle; the engine does not
// enforce this. The write loads the key register, the round keys are registered
// from it in the cycle after, and the next input beat may follow once they are.
module des_block_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_cipher_key,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [63:0] in_data_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_data_out
);
  import des_pkg::*;

  logic  [63:0] key_r;
  rkey_t        rkeys [NumRounds];
  logic         adv;

  // Stage signals; index 0 is the IP stage, index j+1 the output of round j.
  logic  vld [NumRounds+1];
  logic  dec [NumRounds+1];
  half_t lh  [NumRounds+1];
  half_t rh  [NumRounds+1];

  logic   vld0_r;
  logic   dec0_r;
  block_t ip_r;
  logic   out_vld_r;
  block_t out_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_valid) begin
      key_r <= cfg_cipher_key;
    end
  end

  des_key_sched u_sched (
    .clk        (clk),
    .cipher_key (key_r),
    .rkeys      (rkeys)
  );

  // The pipeline moves whenever the output slot is free or being taken.
  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (adv) begin
      vld0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dec0_r <= in_req_type;
      ip_r   <= init_perm(in_data_in);
    end
  end

  assign vld[0] = vld0_r;
  assign dec[0] = dec0_r;
  assign lh[0]  = ip_r[63:32];
  assign rh[0]  = ip_r[31:0];

  for (genvar j = 0; j < NumRounds; j++) begin : g_round
    des_round u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .vld_i   (vld[j]),
      .dec_i   (dec[j]),
      .l_i     (lh[j]),
      .r_i     (rh[j]),
      .key_enc (rkeys[j]),
      .key_dec (rkeys[NumRounds-1-j]),
      .vld_o   (vld[j+1]),
      .dec_o   (dec[j+1]),
      .l_o     (lh[j+1]),
      .r_o     (rh[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= vld[NumRounds];
    end
  end

  // Halves swap before the inverse permutation.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= final_perm({rh[NumRounds], lh[NumRounds]});
    end
  end

  assign out_valid    = out_vld_r;
  assign out_data_out = out_r;

endmodule

// File: tb/des_block_cipher_tb.sv
// ----------------------------------------------------------------------------
// DES block cipher testbench
// Drives encrypt and decrypt beats through the pipelined DES engine under
// several keys, with random idling on both sides, and checks every result
// against a DES model kept in the testbench.
// ----------------------------------------------------------------------------
module des_block_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import des_pkg::*;

  // One pending input beat: the operation and the block.
  typedef struct packed {
    req_t   op;
    block_t blk;
  } cipher_beat_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [63:0] cfg_cipher_key;
  logic        in_valid;
  logic        in_stall;
  logic        in_req_type;
  logic [63:0] in_data_in;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_data_out;

  des_block_cipher dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_cipher_key (cfg_cipher_key),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_data_in     (in_data_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_out   (out_data_out)
  );

  // DrainCycles is the extra wait after the last result is back, a comfortable
  // margin for the pipeline to run dry.
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned IdlePercent = 29;

  cipher_beat_t pending_beats[$];  // beats waiting for the driver
  block_t       expected_blocks[$]; // predicted results, oldest first
  block_t       active_key;         // key the engine currently holds
  bit           in_busy;            // the driven beat has not been accepted yet
  bit           calm;               // no idling on either side while set
  int unsigned  hold_cycles;        // long receiver hold-off, counted down
  int unsigned  quiet_cycles;
  int unsigned  error_count;

  // --------------------------------------------------------------------------
  // DES prediction. The tables come from the package; the permutations, key
  // schedule and round function are written out here.
  // --------------------------------------------------------------------------
  function automatic half_t round_mix(input half_t r, input rkey_t k);
    rkey_t      e;
    half_t      s;
    half_t      p;
    logic [5:0] six;
    int         row;
    int         col;
    for (int i = 0; i < 48; i++) e[47-i] = r[32 - int'(E_TAB[i])];
    e ^= k;
    for (int i = 0; i < 8; i++) begin
      six = e[47-6*i -: 6];
      row = {six[5], six[0]};
      col = six[4:1];
      s[31-4*i -: 4] = SBOX[i][row*16 + col];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32 - int'(P_TAB[i])];
    return p;
  endfunction

  function automatic block_t des_crypt(input block_t key, input req_t op, input block_t blk);
    rkey_t       sched [16];
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    int          n;
    block_t      x;
    half_t       l;
    half_t       r;
    half_t       t;
    block_t      res;
    for (int i = 0; i < 56; i++) cd[55-i] = key[64 - int'(PC1_TAB[i])];
    c = cd[55:28];
    d = cd[27:0];
    for (int j = 0; j < 16; j++) begin
      n = SHIFT_TAB[j];
      c = (c << n) | (c >> (28 - n));
      d = (d << n) | (d >> (28 - n));
      cd = {c, d};
      for (int i = 0; i < 48; i++) sched[j][47-i] = cd[56 - int'(PC2_TAB[i])];
    end
    for (int i = 0; i < 64; i++) x[63-i] = blk[64 - int'(IP_TAB[i])];
    l = x[63:32];
    r = x[31:0];
    for (int j = 0; j < 16; j++) begin
      t = r;
      r = l ^ round_mix(r, sched[(op == REQ_DECRYPT) ? 15 - j : j]);
      l = t;
    end
    x = {r, l};
    for (int i = 0; i < 64; i++) res[63-i] = x[64 - int'(FP_TAB[i])];
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Clock and reset. Reset is asserted at the start only.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Input driver. A new beat is taken from the queue only once the previous
  // one has been accepted, so a stalled payload never changes.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && !in_busy) begin
      if (pending_beats.size() != 0 && (calm || $urandom_range(99) >= IdlePercent)) begin
        cipher_beat_t b;
        b = pending_beats.pop_front();
        in_valid    <= 1'b1;
        in_req_type <= b.op;
        in_data_in  <= b.blk;
        in_busy = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off when requested, so
  // the pipeline fills and backs up into in_stall.
  always @(negedge clk) begin
    if (hold_cycles != 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < IdlePercent);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on every accepted input beat, checks every accepted
  // result beat and tracks key writes. All sampling is at the rising edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      quiet_cycles++;
      if (cfg_valid && cfg_ready) begin
        active_key = cfg_cipher_key;
        quiet_cycles = 0;
      end
      if (in_valid && !in_stall) begin
        expected_blocks.push_back(des_crypt(active_key, req_t'(in_req_type), in_data_in));
        in_busy = 1'b0;
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        if (expected_blocks.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_data_out));
        end else begin
          block_t want;
          want = expected_blocks.pop_front();
          if (out_data_out !== want)
            report_mismatch($sformatf("data_out %h, expected %h", out_data_out, want));
        end
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("[%0t] watchdog: no beat accepted for %0d cycles", $realtime, quiet_cycles);
        $display("des_block_cipher_tb: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequencing.
  // --------------------------------------------------------------------------
  task automatic write_key(input block_t key);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_cipher_key <= key;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    // The round keys settle in the cycle after the write.
    @(negedge clk);
  endtask

  // Sender pause: wait until every queued beat has gone in and every result
  // is back, then let the pipeline run dry before anything else happens.
  task automatic drain();
    while (pending_beats.size() != 0 || in_busy || expected_blocks.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic block_t rand_block();
    return {$urandom(), $urandom()};
  endfunction

  // Random beats, mostly encrypt-then-decrypt pairs under the current key so
  // the round trip is exercised, with plain random beats mixed in.
  task automatic queue_random(input int unsigned count, input block_t key);
    block_t pt;
    block_t ct;
    req_t   op;
    for (int unsigned i = 0; i < count; i++) begin
      pt = rand_block();
      if ($urandom_range(99) < 60) begin
        ct = des_crypt(key, REQ_ENCRYPT, pt);
        pending_beats.push_back('{REQ_ENCRYPT, pt});
        pending_beats.push_back('{REQ_DECRYPT, ct});
        i++;
      end else begin
        op = $urandom_range(1) ? REQ_DECRYPT : REQ_ENCRYPT;
        pending_beats.push_back('{op, pt});
      end
    end
  endtask

  initial begin
    block_t key_set [8];
    block_t key;
    cfg_valid      = 1'b0;
    cfg_cipher_key = '0;
    in_valid       = 1'b0;
    in_req_type    = REQ_ENCRYPT;
    in_data_in     = '0;
    out_stall      = 1'b0;
    in_busy        = 1'b0;
    calm           = 1'b0;
    hold_cycles    = 0;
    quiet_cycles   = 0;
    error_count    = 0;
    active_key     = '0;

    key_set[0] = 64'h1334_5779_9BBC_DFF1;  // the classic textbook key
    key_set[1] = 64'h1235_7878_9ABD_DEF0;  // second fixed key, differs from the first beyond the parity bits
    key_set[2] = 64'hFFFF_FFFF_FFFF_FFFF;
    key_set[3] = 64'h0101_0101_0101_0101;  // weak key
    key_set[4] = 64'hFEFE_FEFE_FEFE_FEFE;  // weak key
    key_set[5] = 64'h01FE_01FE_01FE_01FE;  // semi-weak key
    key_set[6] = rand_block();
    key_set[7] = rand_block();

    @(posedge rst_n);
    @(negedge clk);

    // Directed beats under the reset key of zero, then under the first two keys of the set.
    pending_beats.push_back('{REQ_ENCRYPT, 64'h0});
    pending_beats.push_back('{REQ_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF});
    pending_beats.push_back('{REQ_DECRYPT, 64'h0});
    pending_beats.push_back('{REQ_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF});
    drain();

    for (int k = 0; k < 8; k++) begin
      key = key_set[k];
      write_key(key);
      if (k < 2) begin
        pending_beats.push_back('{REQ_ENCRYPT, 64'h0123_4567_89AB_CDEF});
        pending_beats.push_back('{REQ_DECRYPT, 64'h85E8_1354_0F0A_B405});
        pending_beats.push_back('{REQ_ENCRYPT, 64'h0});
        pending_beats.push_back('{REQ_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF});
        pending_beats.push_back('{REQ_ENCRYPT, 64'h8000_0000_0000_0001});
      end
      // One phase runs without any idling; another holds the receiver off
      // for a long stretch while the sender keeps offering beats.
      calm = (k == 3);
      queue_random(62, key);
      if (k == 5) begin
        @(posedge clk);
        hold_cycles = 80;
      end
      drain();
      calm = 1'b0;
    end

    if (error_count == 0) begin
      $display("des_block_cipher_tb: PASS");
    end else begin
      $display("des_block_cipher_tb: FAIL");
    end
    $finish;
  end

endmodule
